// ===== rtl/fma_pkg.sv =====
`timescale 1ns / 1ps

package fma_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned WIN_W          = 5;
  localparam int unsigned MAX_WINDOW_DEF = 16;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } fma_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                is_raw;
    logic                run_last;
    logic                frame_last;
  } fma_out_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/fma_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module fma_div #(
  parameter int unsigned DVD_W = 21,
  parameter int unsigned DVS_W = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DVD_W-1:0]    dividend_i,
  input  logic [DVS_W-1:0]    divisor_i,
  output logic [DVD_W-1:0]    quotient_o,
  output fma_pkg::div_status_t status_o
);
  import fma_pkg::*;

  localparam int unsigned CntW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DVD_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ===== rtl/forward_moving_average_core.sv =====
`timescale 1ns / 1ps
// Flow: a beat that completes a window goes S_IDLE, S_CHECK, S_DIV (restoring divide of the
//   running sum), S_MEAN; then held samples leave raw from S_TAIL, one per cycle unless stalled.
// A new beat is taken only in S_IDLE, so each beat (mean, raw pass or tail flush, after any
//   output stall) is handed to the output register before the next one is accepted.
// Reset: control, fill count and running sum clear, window length returns to 10; the
//   sample memory is not cleared (only held entries are used).
module forward_moving_average_core #(
  parameter int unsigned MAX_WINDOW = fma_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fma_pkg::fma_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fma_pkg::fma_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [fma_pkg::WIN_W-1:0]   cfg_data_i
);
  import fma_pkg::*;

  // Sizing: fill count can reach MAX_WINDOW, sum holds MAX_WINDOW samples.
  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PtrW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SumW = SAMPLE_W + CntW;
  localparam int unsigned CmpW = (CntW > WIN_W) ? CntW : WIN_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;  // decide: divide, tail, or done
  localparam logic [2:0] S_DIV   = 3'd2;  // wait on the divider
  localparam logic [2:0] S_MEAN  = 3'd3;  // emit mean, drop oldest sample
  localparam logic [2:0] S_TAIL  = 3'd4;  // flush held samples raw
  localparam logic [2:0] S_RAW   = 3'd5;  // zero window: pass sample through

  logic [2:0]          state_q, state_d;
  logic [WIN_W-1:0]    win_q, win_d;
  logic [CntW-1:0]     held_q, held_d;
  logic [SumW-1:0]     total_q, total_d;
  logic [PtrW-1:0]     head_q, head_d;     // oldest held sample
  logic [PtrW-1:0]     wr_q, wr_d;         // next free slot
  logic [SAMPLE_W-1:0] samp_q, samp_d;
  logic                end_q, end_d;
  logic                out_valid_q, out_valid_d;
  fma_out_t            out_q, out_d;

  // Window storage: circular buffer, registered read of the head entry.
  logic [SAMPLE_W-1:0] mem_q [MAX_WINDOW];
  logic [SAMPLE_W-1:0] rd_q;
  logic                mem_we;

  // Effective window: register value clipped to MAX_WINDOW.
  logic [CmpW-1:0]     cfg_ext, max_ext, w_ext;
  logic                in_fire, slot_free, full_win, last_held;

  logic                div_start;
  logic [SumW-1:0]     quotient;
  div_status_t         div_stat;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cfg_ext   = CmpW'(win_q);
  assign max_ext   = CmpW'(MAX_WINDOW);
  assign w_ext     = (cfg_ext > max_ext) ? max_ext : cfg_ext;

  // a window write takes the idle cycle, so no beat is taken alongside it
  assign in_ready_o = (state_q == S_IDLE) && !cfg_we_i;
  assign in_fire    = in_valid_i && in_ready_o;
  // output register can take a new beat this cycle
  assign slot_free  = !out_valid_q || out_ready_i;
  assign full_win   = CmpW'(held_q) >= w_ext;
  assign last_held  = (held_q == CntW'(1));

  fma_div #(
    .DVD_W (SumW),
    .DVS_W (CmpW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_q),
    .divisor_i  (w_ext),
    .quotient_o (quotient),
    .status_o   (div_stat)
  );

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    held_d      = held_q;
    total_d     = total_q;
    head_d      = head_q;
    wr_d        = wr_q;
    samp_d      = samp_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          // new window length drops whatever is pending
          win_d   = cfg_data_i;
          held_d  = '0;
          total_d = '0;
          head_d  = wr_q;
        end else if (in_fire) begin
          samp_d = in_data_i.sample;
          end_d  = in_data_i.frame_end;
          if (w_ext == '0) begin
            state_d = S_RAW;
          end else begin
            if (held_q != CntW'(MAX_WINDOW)) begin
              mem_we  = 1'b1;
              wr_d    = ptr_inc(wr_q);
              held_d  = held_q + 1'b1;
              total_d = total_q + SumW'(in_data_i.sample);
            end
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (full_win) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (end_q && held_q != '0) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.value      = quotient[SAMPLE_W-1:0];
          out_d.is_raw     = 1'b0;
          out_d.run_last   = !end_q || last_held;
          out_d.frame_last = end_q && last_held;
          total_d          = total_q - SumW'(rd_q);
          head_d           = ptr_inc(head_q);
          held_d           = held_q - 1'b1;
          if (end_q && !last_held) begin
            state_d = S_TAIL;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.value      = rd_q;
          out_d.is_raw     = 1'b1;
          out_d.run_last   = last_held;
          out_d.frame_last = last_held;
          total_d          = '0;
          head_d           = ptr_inc(head_q);
          held_d           = held_q - 1'b1;
          if (last_held) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RAW: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.value      = samp_q;
          out_d.is_raw     = 1'b1;
          out_d.run_last   = 1'b1;
          out_d.frame_last = end_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= WINDOW_RESET;
      held_q      <= '0;
      total_q     <= '0;
      head_q      <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      held_q      <= held_d;
      total_q     <= total_d;
      head_q      <= head_d;
      wr_q        <= wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= samp_d;
    end_q  <= end_d;
    out_q  <= out_d;
  end

  // Read follows the next head so rd_q shows the oldest sample once head settles.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_q] <= in_data_i.sample;
    end
    rd_q <= mem_q[head_d];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Between beats the buffer never holds a full window.
  a_held_below_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && w_ext != '0) |-> (CmpW'(held_q) < w_ext))
    else $error("fill count reached window while idle");

  // Divider finishes only while the sequencer waits on it.
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider done outside wait state");

  // Tail flush never runs on an empty buffer.
  a_tail_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL) |-> (held_q != '0))
    else $error("tail flush with empty buffer");

  // A mean is emitted only with a full window held.
  a_mean_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEAN) |-> full_win)
    else $error("mean emitted without full window");

endmodule
